// ----- src/ctit_pkg.sv -----
// Shared widths, constants, payload types and saturation helper for the
// camera target to inertial transform pipeline. No dependencies.
package ctit_pkg;

   // Field and intermediate widths.
   localparam int QUAT_W      = 16;
   localparam int COORD_W     = 24;
   localparam int QPROD_W     = 32;
   localparam int SQ_W        = 33;
   localparam int MAT_W       = 34;
   localparam int BODY_W      = 25;
   localparam int MOUNT_K_W   = 17;
   localparam int MPROD_W     = 42;
   localparam int MUL_W       = 59;
   localparam int ACC_W       = 61;
   localparam int ROT_W       = 33;
   localparam int SUM_W       = 34;
   localparam int MOUNT_SHIFT = 16;
   localparam int ROT_SHIFT   = 28;
   localparam int STAGES      = 6;

   // Mount coefficient 1/1.414 in Q0.16, and rounding offsets.
   localparam logic signed [MOUNT_K_W-1:0] MOUNT_K    = 17'sd46348;
   localparam logic signed [MAT_W-1:0]     ONE_Q28    = 34'sd268435456;
   localparam logic signed [MPROD_W-1:0]   MOUNT_HALF = 42'sd32768;
   localparam logic signed [ACC_W-1:0]     ROT_HALF   = 61'sd134217728;
   localparam logic signed [SUM_W-1:0]     OUT_MAX    = 34'sd8388607;
   localparam logic signed [SUM_W-1:0]     OUT_MIN    = -34'sd8388608;

   typedef logic [STAGES-1:0] stage_en_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [2:0]           coord_vec_type;

   typedef logic signed [BODY_W-1:0] body_elem_type;
   typedef body_elem_type [2:0]      body_vec_type;

   typedef logic signed [MAT_W-1:0] mat_elem_type;
   typedef mat_elem_type [2:0][2:0] mat_type;

   typedef logic signed [ROT_W-1:0] rot_elem_type;
   typedef rot_elem_type [2:0]      rot_vec_type;

   typedef struct packed {
      logic signed [QUAT_W-1:0]  quat_w;
      logic signed [QUAT_W-1:0]  quat_x;
      logic signed [QUAT_W-1:0]  quat_y;
      logic signed [QUAT_W-1:0]  quat_z;
      logic signed [COORD_W-1:0] vehicle_x;
      logic signed [COORD_W-1:0] vehicle_y;
      logic signed [COORD_W-1:0] vehicle_z;
      logic signed [COORD_W-1:0] cam_x;
      logic signed [COORD_W-1:0] cam_y;
      logic signed [COORD_W-1:0] cam_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] body_x;
      logic signed [COORD_W-1:0] body_y;
      logic signed [COORD_W-1:0] body_z;
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_y;
      logic signed [COORD_W-1:0] world_z;
   } rsp_payload_type;

   // Clamp a wide signed value to the 24-bit output range.
   function automatic coord_type sat_coord(input logic signed [SUM_W-1:0] v);
      coord_type r;
      if (v > OUT_MAX) begin
         r = OUT_MAX[COORD_W-1:0];
      end else if (v < OUT_MIN) begin
         r = OUT_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- src/ctit_quat_matrix.sv -----
// Quaternion to rotation matrix unit: three register stages (products,
// matrix entries, alignment). Depends on ctit_pkg.
module ctit_quat_matrix (
   input  logic                     clock,
   input  ctit_pkg::stage_en_type   stage_en,
   input  ctit_pkg::req_payload_type req_data,
   output ctit_pkg::mat_type        mat
);
   import ctit_pkg::*;

   logic signed [QPROD_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [QPROD_W-1:0] wx_ff, wy_ff, wz_ff;
   mat_type mat2_in, mat2_ff, mat3_ff;

   // Diagonal entry: one minus twice the sum of two squares.
   function automatic mat_elem_type diag(input logic signed [QPROD_W-1:0] a,
                                         input logic signed [QPROD_W-1:0] b);
      logic signed [SQ_W-1:0] s;
      s = SQ_W'(a) + SQ_W'(b);
      return ONE_Q28 - (MAT_W'(s) <<< 1);
   endfunction

   // Off-diagonal entry: twice a sum or difference of two products.
   function automatic mat_elem_type offd(input logic signed [QPROD_W-1:0] a,
                                         input logic signed [QPROD_W-1:0] b,
                                         input logic                      neg);
      logic signed [SQ_W-1:0] s;
      s = neg ? (SQ_W'(a) - SQ_W'(b)) : (SQ_W'(a) + SQ_W'(b));
      return MAT_W'(s) <<< 1;
   endfunction

   // Stage one: all quaternion component products.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         xx_ff <= QPROD_W'(req_data.quat_x) * QPROD_W'(req_data.quat_x);
         yy_ff <= QPROD_W'(req_data.quat_y) * QPROD_W'(req_data.quat_y);
         zz_ff <= QPROD_W'(req_data.quat_z) * QPROD_W'(req_data.quat_z);
         xy_ff <= QPROD_W'(req_data.quat_x) * QPROD_W'(req_data.quat_y);
         xz_ff <= QPROD_W'(req_data.quat_x) * QPROD_W'(req_data.quat_z);
         yz_ff <= QPROD_W'(req_data.quat_y) * QPROD_W'(req_data.quat_z);
         wx_ff <= QPROD_W'(req_data.quat_w) * QPROD_W'(req_data.quat_x);
         wy_ff <= QPROD_W'(req_data.quat_w) * QPROD_W'(req_data.quat_y);
         wz_ff <= QPROD_W'(req_data.quat_w) * QPROD_W'(req_data.quat_z);
      end
   end

   // Stage two: the nine entries of the unnormalized rotation matrix.
   always_comb begin
      mat2_in[0][0] = diag(yy_ff, zz_ff);
      mat2_in[0][1] = offd(xy_ff, wz_ff, 1'b1);
      mat2_in[0][2] = offd(xz_ff, wy_ff, 1'b0);
      mat2_in[1][0] = offd(xy_ff, wz_ff, 1'b0);
      mat2_in[1][1] = diag(xx_ff, zz_ff);
      mat2_in[1][2] = offd(yz_ff, wx_ff, 1'b1);
      mat2_in[2][0] = offd(xz_ff, wy_ff, 1'b1);
      mat2_in[2][1] = offd(yz_ff, wx_ff, 1'b0);
      mat2_in[2][2] = diag(xx_ff, yy_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         mat2_ff <= mat2_in;
      end
   end

   // Stage three: hold the matrix so it lines up with the body point.
   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         mat3_ff <= mat2_ff;
      end
   end

   assign mat = mat3_ff;

endmodule

// ----- src/ctit_mount.sv -----
// Camera mount unit: maps the camera point to the body frame through the
// fixed 45-degree-down mount inverse in three stages. Depends on ctit_pkg.
module ctit_mount (
   input  logic                      clock,
   input  ctit_pkg::stage_en_type    stage_en,
   input  ctit_pkg::req_payload_type req_data,
   output ctit_pkg::body_vec_type    body
);
   import ctit_pkg::*;

   body_elem_type dif_ff, add_ff, cx1_ff, cx2_ff;
   logic signed [MPROD_W-1:0] mdif_ff, madd_ff;
   logic signed [MPROD_W-1:0] mdif_rnd, madd_rnd;
   body_vec_type body_ff;

   // Stage one: difference and sum of the camera y and z axes.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         dif_ff <= BODY_W'(req_data.cam_z) - BODY_W'(req_data.cam_y);
         add_ff <= BODY_W'(req_data.cam_y) + BODY_W'(req_data.cam_z);
         cx1_ff <= BODY_W'(req_data.cam_x);
      end
   end

   // Stage two: scale both by the mount coefficient.
   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         mdif_ff <= MPROD_W'(dif_ff) * MPROD_W'(MOUNT_K);
         madd_ff <= MPROD_W'(add_ff) * MPROD_W'(MOUNT_K);
         cx2_ff  <= cx1_ff;
      end
   end

   // Stage three: round half up and drop the fraction bits.
   assign mdif_rnd = mdif_ff + MOUNT_HALF;
   assign madd_rnd = madd_ff + MOUNT_HALF;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         body_ff[0] <= mdif_rnd[BODY_W+MOUNT_SHIFT-1:MOUNT_SHIFT];
         body_ff[1] <= cx2_ff;
         body_ff[2] <= madd_rnd[BODY_W+MOUNT_SHIFT-1:MOUNT_SHIFT];
      end
   end

   assign body = body_ff;

endmodule

// ----- src/ctit_rotate.sv -----
// Rotation unit: multiplies the body point by the matrix (stage four) and
// sums and rounds each row (stage five). Depends on ctit_pkg.
module ctit_rotate (
   input  logic                   clock,
   input  ctit_pkg::stage_en_type stage_en,
   input  ctit_pkg::mat_type      mat,
   input  ctit_pkg::body_vec_type body,
   output ctit_pkg::rot_vec_type  rot,
   output ctit_pkg::body_vec_type body_out
);
   import ctit_pkg::*;

   logic signed [MUL_W-1:0] prod_in [3][3];
   logic signed [MUL_W-1:0] prod_ff [3][3];
   logic signed [ACC_W-1:0] acc [3];
   rot_vec_type  rot_in, rot_ff;
   body_vec_type body4_ff, body5_ff;

   // Stage four: nine matrix-by-coordinate products.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = MUL_W'(mat[i][j]) * MUL_W'(body[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         prod_ff  <= prod_in;
         body4_ff <= body;
      end
   end

   // Stage five: row sums, rounded half up and scaled down from Q2.28.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc[i] = ACC_W'(prod_ff[i][0]) + ACC_W'(prod_ff[i][1])
                + ACC_W'(prod_ff[i][2]) + ROT_HALF;
         rot_in[i] = acc[i][ACC_W-1:ROT_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         rot_ff   <= rot_in;
         body5_ff <= body4_ff;
      end
   end

   assign rot      = rot_ff;
   assign body_out = body5_ff;

endmodule

// ----- src/camera_target_to_inertial_transform_core.sv -----
// Camera target to inertial transform: top level with stage control and
// output register. Depends on ctit_pkg, ctit_quat_matrix, ctit_mount, ctit_rotate.
// An accepted request passes through every stage register before rsp_valid; one
// item per cycle is accepted while rsp_stall stays low.
// Each stage moves forward when empty or when the next one moves, so bubbles close up.
// Reset clears only the stage valid bits; payload registers are not reset.
module camera_target_to_inertial_transform_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ctit_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ctit_pkg::rsp_payload_type rsp_data
);
   import ctit_pkg::*;

   logic [STAGES-1:0] valid_ff, valid_in;
   stage_en_type      stage_en;
   coord_vec_type     pos_ff [STAGES-1];
   coord_vec_type     pos_in;
   mat_type           mat;
   body_vec_type      body, body_rot;
   rot_vec_type       rot;
   rsp_payload_type   rsp_in, rsp_ff;

   // Stage enables: a stage loads when it is empty or its successor loads.
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !stage_en[0];

   // Vehicle position travels alongside the arithmetic stages.
   assign pos_in[0] = req_data.vehicle_x;
   assign pos_in[1] = req_data.vehicle_y;
   assign pos_in[2] = req_data.vehicle_z;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         pos_ff[0] <= pos_in;
      end
      for (int k = 1; k < STAGES - 1; k++) begin
         if (stage_en[k]) begin
            pos_ff[k] <= pos_ff[k-1];
         end
      end
   end

   ctit_quat_matrix u_quat_matrix (
      .clock    (clock),
      .stage_en (stage_en),
      .req_data (req_data),
      .mat      (mat)
   );

   ctit_mount u_mount (
      .clock    (clock),
      .stage_en (stage_en),
      .req_data (req_data),
      .body     (body)
   );

   ctit_rotate u_rotate (
      .clock    (clock),
      .stage_en (stage_en),
      .mat      (mat),
      .body     (body),
      .rot      (rot),
      .body_out (body_rot)
   );

   // Stage six: add the vehicle position and saturate every field.
   always_comb begin
      rsp_in.body_x  = sat_coord(SUM_W'(body_rot[0]));
      rsp_in.body_y  = sat_coord(SUM_W'(body_rot[1]));
      rsp_in.body_z  = sat_coord(SUM_W'(body_rot[2]));
      rsp_in.world_x = sat_coord(SUM_W'(rot[0]) + SUM_W'(pos_ff[STAGES-2][0]));
      rsp_in.world_y = sat_coord(SUM_W'(rot[1]) + SUM_W'(pos_ff[STAGES-2][1]));
      rsp_in.world_z = sat_coord(SUM_W'(rot[2]) + SUM_W'(pos_ff[STAGES-2][2]));
   end

   always_ff @(posedge clock) begin
      if (stage_en[STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[STAGES-1];
   assign rsp_data  = rsp_ff;

endmodule
